FILE: sv/gapc_pkg.sv
// shared codes, reset values and widths of the glyph alpha pixel converter
package gapc_pkg;

    // output format codes
    localparam logic [3:0] FMT_ARGB     = 4'd0;
    localparam logic [3:0] FMT_ABGR     = 4'd1;
    localparam logic [3:0] FMT_AIRGB    = 4'd2;
    localparam logic [3:0] FMT_8565     = 4'd3;
    localparam logic [3:0] FMT_1666     = 4'd4;
    localparam logic [3:0] FMT_6666     = 4'd5;
    localparam logic [3:0] FMT_4444     = 4'd6;
    localparam logic [3:0] FMT_RGBA4444 = 4'd7;
    localparam logic [3:0] FMT_2554     = 4'd8;
    localparam logic [3:0] FMT_1555     = 4'd9;
    localparam logic [3:0] FMT_5551     = 4'd10;
    localparam logic [3:0] FMT_F88871   = 4'd11;
    localparam logic [3:0] FMT_A8       = 4'd12;
    localparam logic [3:0] FMT_A4       = 4'd13;
    localparam logic [3:0] FMT_A1       = 4'd14;
    localparam logic [3:0] FMT_A1LSB    = 4'd15;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_SOURCE_MODE = 2'd0;
    localparam logic [1:0] REG_OUT_FORMAT  = 2'd1;
    localparam logic [1:0] REG_PREMULTIPLY = 2'd2;
    localparam logic [1:0] REG_BIG_ENDIAN  = 2'd3;

    localparam logic [3:0] OUT_FORMAT_RESET = FMT_A8;

    // byte counts
    localparam logic [2:0] BYTES_1 = 3'd1;
    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_3 = 3'd3;
    localparam logic [2:0] BYTES_4 = 3'd4;

    // last pixel slot of a packed byte
    localparam logic [2:0] A1_LAST_POS = 3'd7;

    // swap the outer bytes of a three-byte word when requested
    function automatic logic [31:0] order3(input logic [23:0] d, input logic big_endian);
        logic [31:0] r;
        r = big_endian ? {8'h00, d[7:0], d[15:8], d[23:16]} : {8'h00, d};
        return r;
    endfunction

endpackage

FILE: sv/glyph_alpha_pixel_converter_top.sv
// glyph coverage sample to alpha pixel format converter, top level
//
//  channel  | signals                               | payload
//  ---------+---------------------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata/tlast      | tdata[7:0] pixel_value, tlast row_end
//  m_axis   | m_axis_tvalid/tready/tdata/tlast      | tdata[31:0] pixel_data,
//           |                                       | tdata[34:32] byte_count, tlast row_done
//  apb      | psel/penable/pwrite/paddr/pwdata/...  | four config registers, read as 32-bit words
//
// one sample accepted per clock while the output is not held; conversion and packing
// are a single combinational pass from the accepted sample into the output register,
// so a result is registered in the cycle after its sample is accepted.
// packed formats (A4, A1, A1 LSB) give a result only when a byte fills or at row end.
// reset clears the config registers, the packing state and the output valid flag.
// the input is held off only while the output register is full and not taken.
module glyph_alpha_pixel_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic        s_axis_tlast,   // row_end
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] pixel_data, [34:32] byte_count, [39:35] zero
    output logic        m_axis_tlast,   // row_done
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic       source_mode_reg;
    logic [3:0] out_format_reg;
    logic       premultiply_reg;
    logic       big_endian_reg;

    // packing state
    logic [7:0] pack_acc_reg, pack_acc_next;
    logic [2:0] pack_pos_reg, pack_pos_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [2:0]  out_count_reg, out_count_next;
    logic        out_last_reg, out_last_next;

    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       s_accept;
    logic       m_accept;
    logic       mono;
    logic [7:0] alpha8;
    logic       packed_fmt;
    logic [7:0] acc_or;
    logic       pack_full;
    logic [2:0] pos_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_count_reg, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

    // register read back
    always_comb
    begin
        case (cfg_index)
            gapc_pkg::REG_SOURCE_MODE: prdata = {31'd0, source_mode_reg};
            gapc_pkg::REG_OUT_FORMAT:  prdata = {28'd0, out_format_reg};
            gapc_pkg::REG_PREMULTIPLY: prdata = {31'd0, premultiply_reg};
            gapc_pkg::REG_BIG_ENDIAN:  prdata = {31'd0, big_endian_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg <= 1'b0;
            out_format_reg  <= gapc_pkg::OUT_FORMAT_RESET;
            premultiply_reg <= 1'b0;
            big_endian_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gapc_pkg::REG_SOURCE_MODE: source_mode_reg <= pwdata[0];
                gapc_pkg::REG_OUT_FORMAT:  out_format_reg  <= pwdata[3:0];
                gapc_pkg::REG_PREMULTIPLY: premultiply_reg <= pwdata[0];
                gapc_pkg::REG_BIG_ENDIAN:  big_endian_reg  <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    // coverage as an 8-bit alpha, mono bit replicated
    assign mono   = source_mode_reg;
    assign alpha8 = mono ? {8{s_axis_tdata[0]}} : s_axis_tdata;

    assign packed_fmt = out_format_reg inside {gapc_pkg::FMT_A4, gapc_pkg::FMT_A1,
                                               gapc_pkg::FMT_A1LSB};

    // packing of A4 and A1 formats
    always_comb
    begin
        acc_or    = 8'h00;
        pack_full = 1'b0;
        pos_inc   = pack_pos_reg + 3'd1;
        case (out_format_reg)
            gapc_pkg::FMT_A4:
            begin
                acc_or    = pack_pos_reg[0] ? {4'h0, alpha8[7:4]} : {alpha8[7:4], 4'h0};
                pack_full = pack_pos_reg[0];
                pos_inc   = {2'b00, pack_pos_reg[0]} + 3'd1;
            end
            gapc_pkg::FMT_A1:
            begin
                acc_or    = {7'd0, alpha8[7]} << (3'd7 - pack_pos_reg);
                pack_full = pack_pos_reg == gapc_pkg::A1_LAST_POS;
            end
            gapc_pkg::FMT_A1LSB:
            begin
                acc_or    = {7'd0, alpha8[7]} << pack_pos_reg;
                pack_full = pack_pos_reg == gapc_pkg::A1_LAST_POS;
            end
            default:
            begin
                acc_or    = 8'h00;
                pack_full = 1'b0;
            end
        endcase
    end

    // pixel conversion and next-state selection
    always_comb
    begin
        pack_acc_next  = pack_acc_reg;
        pack_pos_next  = pack_pos_reg;
        out_valid_next = out_valid_reg && !m_accept;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (cfg_write)
        begin
            pack_acc_next = 8'h00;
            pack_pos_next = 3'd0;
        end
        else if (s_accept)
        begin
            out_last_next = s_axis_tlast;
            if (packed_fmt)
            begin
                if (pack_full || s_axis_tlast)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {24'd0, pack_acc_reg | acc_or};
                    out_count_next = gapc_pkg::BYTES_1;
                    pack_acc_next  = 8'h00;
                    pack_pos_next  = 3'd0;
                end
                else
                begin
                    pack_acc_next = pack_acc_reg | acc_or;
                    pack_pos_next = pos_inc;
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                case (out_format_reg)
                    gapc_pkg::FMT_ARGB, gapc_pkg::FMT_ABGR:
                    begin
                        out_data_next  = premultiply_reg ? {4{alpha8}} : {alpha8, 24'hFFFFFF};
                        out_count_next = gapc_pkg::BYTES_4;
                    end
                    gapc_pkg::FMT_AIRGB:
                    begin
                        out_data_next  = {~alpha8, 24'hFFFFFF};
                        out_count_next = gapc_pkg::BYTES_4;
                    end
                    gapc_pkg::FMT_8565:
                    begin
                        out_data_next  = gapc_pkg::order3({alpha8, 16'hFFFF}, big_endian_reg);
                        out_count_next = gapc_pkg::BYTES_3;
                    end
                    gapc_pkg::FMT_1666, gapc_pkg::FMT_6666:
                    begin
                        out_data_next  = gapc_pkg::order3({alpha8[7:2], 18'h3FFFF},
                                                          big_endian_reg);
                        out_count_next = gapc_pkg::BYTES_3;
                    end
                    gapc_pkg::FMT_4444:
                    begin
                        out_data_next  = {16'd0, alpha8[7:4], 12'hFFF};
                        out_count_next = gapc_pkg::BYTES_2;
                    end
                    gapc_pkg::FMT_RGBA4444:
                    begin
                        out_data_next  = {16'd0, 12'hFFF, alpha8[7:4]};
                        out_count_next = gapc_pkg::BYTES_2;
                    end
                    gapc_pkg::FMT_2554:
                    begin
                        out_data_next  = {16'd0, alpha8[7:6], 14'h3FFF};
                        out_count_next = gapc_pkg::BYTES_2;
                    end
                    gapc_pkg::FMT_1555:
                    begin
                        out_data_next  = {16'd0, alpha8[7], 15'h7FFF};
                        out_count_next = gapc_pkg::BYTES_2;
                    end
                    gapc_pkg::FMT_5551:
                    begin
                        out_data_next  = {16'd0, 15'h7FFF, alpha8[7]};
                        out_count_next = gapc_pkg::BYTES_2;
                    end
                    gapc_pkg::FMT_F88871:
                    begin
                        out_data_next  = {24'hFFFFFF, alpha8[7:1], 1'b0};
                        out_count_next = gapc_pkg::BYTES_4;
                    end
                    default:
                    begin
                        // A8
                        out_data_next  = {24'd0, alpha8};
                        out_count_next = gapc_pkg::BYTES_1;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_acc_reg  <= 8'h00;
            pack_pos_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pack_acc_reg  <= pack_acc_next;
            pack_pos_reg  <= pack_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

`ifndef ASSERT_OFF
    // a valid result always carries one to four bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg == gapc_pkg::BYTES_1 ||
                           out_count_reg == gapc_pkg::BYTES_2 ||
                           out_count_reg == gapc_pkg::BYTES_3 ||
                           out_count_reg == gapc_pkg::BYTES_4))
        else $error("byte count out of range");

    // every sample of an unpacked format gives a result next cycle
    a_unpacked_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !packed_fmt && !cfg_write) |=> out_valid_reg)
        else $error("unpacked sample gave no result");

    // A4 never holds more than one nibble
    a_a4_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_format_reg == gapc_pkg::FMT_A4) |-> (pack_pos_reg <= 3'd1))
        else $error("A4 packing position overrun");

    // a config write drops the partial byte
    a_cfg_clears_pack: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (pack_pos_reg == 3'd0 && pack_acc_reg == 8'h00))
        else $error("config write did not clear packing state");
`endif

endmodule
